// File: hdl/olar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_pkg
// Shared types and codes for the ordered list with append and remove.
// ----------------------------------------------------------------------------
package olar_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 6;

  // Action codes on the command channel
  localparam logic [1:0] ACT_APPEND  = 2'd0;
  localparam logic [1:0] ACT_REMOVE  = 2'd1;
  localparam logic [1:0] ACT_READOUT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_APPEND_ACK = 2'd0;
  localparam logic [1:0] KIND_REMOVE_ACK = 2'd1;
  localparam logic [1:0] KIND_ENTRY      = 2'd2;
  localparam logic [1:0] KIND_END        = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_READOUT
  } state_t;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    logic                     shift;
    logic                     load;
    logic [CNT_W-1:0]         load_idx;
    logic signed [DATA_W-1:0] load_data;
  } cell_cmd_t;

endpackage

// File: hdl/olar_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_cell
// One list slot. Takes its right neighbor's word on a shift, or a new word
// when the load index names this slot.
// ----------------------------------------------------------------------------
module olar_cell
  import olar_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] right_in,
  output logic signed [DATA_W-1:0] data
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  // Load wins over shift so the tail slot can take the recycled head
  always_ff @(posedge clk) begin
    if (cmd.load && (cmd.load_idx == IDX)) begin
      data <= cmd.load_data;
    end else if (cmd.shift) begin
      data <= right_in;
    end
  end

endmodule

// File: hdl/olar_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olar_seq
// Sequencer: accepts commands, drives the cell chain, holds the result item.
// ----------------------------------------------------------------------------
module olar_seq
  import olar_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic [1:0]               action,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] head,
  output cell_cmd_t                cmd,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [1:0]               kind,
  output logic signed [DATA_W-1:0] item_value,
  output logic                     found,
  output logic                     full_drop,
  output logic [CNT_W-1:0]         entry_count,
  output logic                     last
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         occ;
  logic [CNT_W-1:0]         steps;
  logic                     hit_seen;
  logic signed [DATA_W-1:0] key;

  logic                     slot_free;
  logic                     accept;
  logic                     step;
  logic                     hit;
  logic                     emit;
  logic [1:0]               emit_kind;
  logic signed [DATA_W-1:0] emit_value;
  logic                     emit_found;
  logic                     emit_drop;
  logic [CNT_W-1:0]         emit_count;
  logic                     emit_last;
  logic [CNT_W-1:0]         occ_next;

  assign slot_free = !res_valid || !res_stall;
  assign cmd_stall = !((state == S_IDLE) && slot_free);
  assign accept    = cmd_valid && !cmd_stall;
  assign hit       = !hit_seen && (head == key);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (action == ACT_REMOVE)) begin
          state_next = S_REMOVE;
        end else if (accept && (action == ACT_READOUT)) begin
          state_next = S_READOUT;
        end
      end
      S_REMOVE: begin
        if ((steps == '0) && slot_free) state_next = S_IDLE;
      end
      S_READOUT: begin
        if ((steps == '0) && slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Chain commands and result generation
  always_comb begin
    cmd        = '0;
    step       = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_APPEND_ACK;
    emit_value = '0;
    emit_found = 1'b0;
    emit_drop  = 1'b0;
    emit_count = occ;
    emit_last  = 1'b1;
    occ_next   = occ;
    case (state)
      S_IDLE: begin
        if (accept && (action == ACT_APPEND)) begin
          emit = 1'b1;
          if (occ < CAP) begin
            cmd.load      = 1'b1;
            cmd.load_idx  = occ;
            cmd.load_data = value;
            occ_next      = occ + 1'b1;
          end else begin
            emit_drop = 1'b1;
          end
          emit_count = occ_next;
        end
      end
      S_REMOVE: begin
        if (steps != '0) begin
          // pop the head; recycle it to the tail unless it is the first match
          step      = 1'b1;
          cmd.shift = 1'b1;
          if (hit) begin
            occ_next = occ - 1'b1;
          end else begin
            cmd.load      = 1'b1;
            cmd.load_idx  = occ - 1'b1;
            cmd.load_data = head;
          end
        end else if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_REMOVE_ACK;
          emit_found = hit_seen;
        end
      end
      S_READOUT: begin
        if (slot_free) begin
          emit = 1'b1;
          if (steps != '0) begin
            // emit the head and rotate it to the tail
            step          = 1'b1;
            cmd.shift     = 1'b1;
            cmd.load      = 1'b1;
            cmd.load_idx  = occ - 1'b1;
            cmd.load_data = head;
            emit_kind     = KIND_ENTRY;
            emit_value    = head;
            emit_last     = 1'b0;
          end else begin
            emit_kind = KIND_END;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      steps     <= '0;
      hit_seen  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (accept) begin
        steps    <= occ;
        hit_seen <= 1'b0;
      end else if (step) begin
        steps <= steps - 1'b1;
        if ((state == S_REMOVE) && hit) hit_seen <= 1'b1;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload and remove key
  always_ff @(posedge clk) begin
    if (accept) key <= value;
    if (emit) begin
      kind        <= emit_kind;
      item_value  <= emit_value;
      found       <= emit_found;
      full_drop   <= emit_drop;
      entry_count <= emit_count;
      last        <= emit_last;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= CAP)
    else $error("occupancy above capacity");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (steps <= occ))
    else $error("pass counter exceeds occupancy");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE) && hit_seen && (steps != '0) |-> (occ_next == occ))
    else $error("second entry removed in one pass");

  a_entry_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (kind == KIND_ENTRY) |-> !last)
    else $error("list entry flagged as last");

endmodule

// File: hdl/ordered_list_append_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// Fixed-capacity ordered list of signed words held in a chain of cells.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// command  in         cmd_valid / cmd_stall action, value
// result   out        res_valid / res_stall kind, item_value, found, full_drop,
//                                           entry_count, last
//
// An append's ack is loaded at the accept edge. A remove runs through the
// accept, one chain rotation per held entry, and the ack. A read-out runs
// through the same steps and gives count + 1 results, one entry per rotation
// and then the end marker.
// Reset clears the count and the sequencer; cell contents are not reset.
// A stalled result holds a read-out's rotation and blocks new commands.
// ----------------------------------------------------------------------------
module ordered_list_append_remove
  import olar_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic [1:0]               action,
  input  logic signed [DATA_W-1:0] value,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [1:0]               kind,
  output logic signed [DATA_W-1:0] item_value,
  output logic                     found,
  output logic                     full_drop,
  output logic [CNT_W-1:0]         entry_count,
  output logic                     last
);

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  olar_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .action      (action),
    .value       (value),
    .head        (cell_data[0]),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .item_value  (item_value),
    .found       (found),
    .full_drop   (full_drop),
    .entry_count (entry_count),
    .last        (last)
  );

  // Chain of slots, each shifting toward the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] right_in;
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = cell_data[i];
    end else begin : g_body
      assign right_in = cell_data[i+1];
    end
    olar_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .right_in (right_in),
      .data     (cell_data[i])
    );
  end

endmodule

// File: verif/tb_ordered_list_append_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_append_remove
// Self-checking bench for the fixed-capacity ordered list.
// A shadow copy of the list predicts the acks, the listed entries and the end
// marker of every command. Each result is checked against the oldest
// prediction. The stimulus runs in stages: edge values, a fill to capacity
// with overflow, pauses until the result queue empties, a random mix of
// commands, and a drain back to empty. Both channels idle at random, except
// for one stage that runs without gaps.
// ----------------------------------------------------------------------------
module tb_ordered_list_append_remove;
  import olar_pkg::*;

  localparam int          LIST_CAP   = 32;
  localparam int          IDLE_LIMIT = 1000;
  localparam int          TAIL_WAIT  = 40;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] item_value;
    logic                     found;
    logic                     full_drop;
    logic [CNT_W-1:0]         entry_count;
    logic                     last;
  } list_result_t;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     cmd_valid   = 1'b0;
  logic                     cmd_stall;
  logic [1:0]               action      = ACT_APPEND;
  logic signed [DATA_W-1:0] value       = '0;
  logic                     res_valid;
  logic                     res_stall   = 1'b0;
  logic [1:0]               kind;
  logic signed [DATA_W-1:0] item_value;
  logic                     found;
  logic                     full_drop;
  logic [CNT_W-1:0]         entry_count;
  logic                     last;

  // Shadow list, head at index 0, and the results still owed by the block
  logic signed [DATA_W-1:0] shadow_list[$];
  list_result_t             owed_results[$];
  int                       mismatches = 0;
  bit                       no_gaps    = 1'b0;
  int                       idle_cycles = 0;

  list_result_t             seen;
  list_result_t             want;
  bit                       seen_valid;

  ordered_list_append_remove #(
    .CAPACITY (LIST_CAP)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .action      (action),
    .value       (value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .item_value  (item_value),
    .found       (found),
    .full_drop   (full_drop),
    .entry_count (entry_count),
    .last        (last)
  );

  always #5 clk = ~clk;

  // Queue one predicted result
  function automatic void owe(input logic [1:0] k, input logic signed [DATA_W-1:0] v,
                              input logic f, input logic d, input logic l);
    list_result_t r;
    r.kind        = k;
    r.item_value  = v;
    r.found       = f;
    r.full_drop   = d;
    r.entry_count = CNT_W'(shadow_list.size());
    r.last        = l;
    owed_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow list and queue its results
  function automatic void apply_list_op(input logic [1:0] act,
                                        input logic signed [DATA_W-1:0] val);
    int hit;
    hit = -1;
    case (act)
      ACT_APPEND: begin
        if (shadow_list.size() < LIST_CAP) begin
          shadow_list.push_back(val);
          owe(KIND_APPEND_ACK, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          owe(KIND_APPEND_ACK, '0, 1'b0, 1'b1, 1'b1);
        end
      end
      ACT_REMOVE: begin
        foreach (shadow_list[i]) begin
          if (hit < 0 && shadow_list[i] == val) hit = i;
        end
        if (hit >= 0) shadow_list.delete(hit);
        owe(KIND_REMOVE_ACK, '0, hit >= 0, 1'b0, 1'b1);
      end
      ACT_READOUT: begin
        foreach (shadow_list[i]) owe(KIND_ENTRY, shadow_list[i], 1'b0, 1'b0, 1'b0);
        owe(KIND_END, '0, 1'b0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Pick a value: often one already held, often a small one, else any word
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    if (r < 70)
      return DATA_W'($signed($urandom_range(8)) - 4);
    return $urandom;
  endfunction

  // Send one item; entered and left at a falling edge, valid left high
  task automatic send_cmd(input logic [1:0] act, input logic signed [DATA_W-1:0] val);
    while (!no_gaps && $urandom_range(99) < 14) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    action    <= act;
    value     <= val;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    apply_list_op(act, val);
    @(negedge clk);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_edge_cases();
    send_cmd(ACT_READOUT, '0);
    send_cmd(ACT_REMOVE, 32'sd5);
    send_cmd(ACT_APPEND, 32'sh7FFF_FFFF);
    send_cmd(ACT_APPEND, 32'sh8000_0000);
    send_cmd(ACT_APPEND, 32'sd0);
    send_cmd(ACT_APPEND, -32'sd1);
    send_cmd(ACT_APPEND, 32'sd7);
    send_cmd(ACT_APPEND, 32'sd7);
    send_cmd(ACT_READOUT, 32'sh5A5A_A5A5);
    send_cmd(ACT_REMOVE, 32'sd7);
    send_cmd(ACT_REMOVE, 32'sd12345);
    send_cmd(ACT_REMOVE, 32'sh8000_0000);
    send_cmd(ACT_UNUSED, 32'sh7FFF_FFFF);
    send_cmd(ACT_READOUT, '0);
    send_cmd(ACT_REMOVE, -32'sd1);
    send_cmd(ACT_REMOVE, 32'sh7FFF_FFFF);
    send_cmd(ACT_REMOVE, 32'sd0);
    send_cmd(ACT_REMOVE, 32'sd7);
    send_cmd(ACT_READOUT, '0);
    send_cmd(ACT_REMOVE, 32'sd7);
  endtask

  // Fill past capacity with no idling on either side, then thin out
  task automatic test_fill_to_capacity();
    int extra;
    no_gaps = 1'b1;
    extra = 2 + $urandom_range(3);
    while (shadow_list.size() < LIST_CAP) send_cmd(ACT_APPEND, pick_value());
    repeat (extra) send_cmd(ACT_APPEND, $urandom);
    send_cmd(ACT_READOUT, $urandom);
    repeat (LIST_CAP / 2)
      send_cmd(ACT_REMOVE, shadow_list[$urandom_range(shadow_list.size() - 1)]);
    send_cmd(ACT_READOUT, '0);
    no_gaps = 1'b0;
  endtask

  // Let the result queue run dry between small groups of items
  task automatic test_pause_until_drained();
    repeat (3) send_cmd(ACT_APPEND, pick_value());
    send_cmd(ACT_READOUT, '0);
    wait_drained();
    send_cmd(ACT_REMOVE, pick_value());
    send_cmd(ACT_READOUT, '0);
    wait_drained();
    send_cmd(ACT_APPEND, pick_value());
  endtask

  task automatic test_random_mix(input int n_items);
    int r;
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < 45)      send_cmd(ACT_APPEND, pick_value());
      else if (r < 80) send_cmd(ACT_REMOVE, pick_value());
      else if (r < 95) send_cmd(ACT_READOUT, $urandom);
      else             send_cmd(ACT_UNUSED, $urandom);
    end
  endtask

  // Remove held entries in random order until the list is empty
  task automatic test_drain_to_empty();
    while (shadow_list.size() != 0)
      send_cmd(ACT_REMOVE, shadow_list[$urandom_range(shadow_list.size() - 1)]);
    send_cmd(ACT_READOUT, '0);
    send_cmd(ACT_REMOVE, $urandom);
  endtask

  // Stall the result channel at random
  always @(negedge clk) begin
    res_stall <= !no_gaps && ($urandom_range(99) < 14);
  end

  // Capture each result at the rising edge, compare at the falling edge
  always begin
    @(posedge clk);
    seen_valid = !rst && res_valid && !res_stall;
    seen.kind        = kind;
    seen.item_value  = item_value;
    seen.found       = found;
    seen.full_drop   = full_drop;
    seen.entry_count = entry_count;
    seen.last        = last;
    @(negedge clk);
    if (seen_valid) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result expected none actual kind %0d value %0d count %0d",
                 $time, seen.kind, seen.item_value, seen.entry_count);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (seen.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, seen.kind);
          mismatches++;
        end
        if (seen.item_value !== want.item_value) begin
          $display("%0t: item_value expected %0d actual %0d",
                   $time, want.item_value, seen.item_value);
          mismatches++;
        end
        if (seen.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, seen.found);
          mismatches++;
        end
        if (seen.full_drop !== want.full_drop) begin
          $display("%0t: full_drop expected %0b actual %0b",
                   $time, want.full_drop, seen.full_drop);
          mismatches++;
        end
        if (seen.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, seen.entry_count);
          mismatches++;
        end
        if (seen.last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, seen.last);
          mismatches++;
        end
      end
    end
  end

  // Abort when neither channel has moved an item for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_cases();
    test_fill_to_capacity();
    test_pause_until_drained();
    test_random_mix(220);
    test_drain_to_empty();

    // Let the last results arrive, then watch for strays
    wait_drained();
    repeat (TAIL_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/olar_pkg.sv
hdl/olar_cell.sv
hdl/olar_seq.sv
hdl/ordered_list_append_remove.sv
verif/tb_ordered_list_append_remove.sv
